@@ rtl/pai_pkg.sv @@
`default_nettype none

package pai_pkg;

	// configuration port
	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_TIME_STEP = 1'b0;

	// divider: quotient bits resolved per pipeline stage
	localparam int Q_W = 16;
	localparam int DIV_BITS = 2;
	localparam int DIV_STAGES = Q_W / DIV_BITS;

	localparam logic [63:0] HALF_Q16 = 64'd32768;

	// record carried through the input and divider stages
	typedef struct packed {
		logic [31:0] na;
		logic expired;
		logic [31:0] life;
		logic [31:0] rem;
		logic [Q_W-1:0] quo;
		logic [31:0] sc;
		logic [31:0] ec;
		logic [31:0] se;
		logic [31:0] ee;
		logic neg_x;
		logic neg_y;
		logic [31:0] mag_x;
		logic [31:0] mag_y;
		logic [31:0] spx;
		logic [31:0] spy;
		logic [63:0] prod_x;
		logic [63:0] prod_y;
		logic [31:0] vx;
		logic [31:0] vy;
	} rec_t;

	// record after the interpolation multiplies
	typedef struct packed {
		logic [31:0] na;
		logic expired;
		logic [31:0] sc;
		logic [31:0] se;
		logic [3:0][25:0] cprod;
		logic [49:0] eprod;
		logic [31:0] spx;
		logic [31:0] spy;
		logic [31:0] vx;
		logic [31:0] vy;
	} mul_t;

	// finished result word
	typedef struct packed {
		logic [31:0] na;
		logic expired;
		logic [3:0][7:0] colour;
		logic [31:0] extent;
		logic [31:0] sx;
		logic [31:0] sy;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/pai_if.sv @@
`default_nettype none

// particle record channel
interface pai_in_if;
	logic valid;
	logic ready;
	logic [31:0] particle_age;
	logic [31:0] life_span;
	logic [31:0] start_colour;
	logic [31:0] end_colour;
	logic [31:0] start_extent;
	logic [31:0] end_extent;
	logic signed [31:0] pull_x;
	logic signed [31:0] pull_y;
	logic signed [31:0] speed_x_in;
	logic signed [31:0] speed_y_in;

	modport source (
		output valid, particle_age, life_span, start_colour, end_colour,
		output start_extent, end_extent, pull_x, pull_y, speed_x_in, speed_y_in,
		input ready
	);
	modport sink (
		input valid, particle_age, life_span, start_colour, end_colour,
		input start_extent, end_extent, pull_x, pull_y, speed_x_in, speed_y_in,
		output ready
	);
endinterface

// updated record channel
interface pai_out_if;
	logic valid;
	logic ready;
	logic [31:0] new_age;
	logic expired;
	logic [7:0] colour_r;
	logic [7:0] colour_g;
	logic [7:0] colour_b;
	logic [7:0] colour_a;
	logic [31:0] extent_out;
	logic signed [31:0] speed_x_out;
	logic signed [31:0] speed_y_out;

	modport source (
		output valid, new_age, expired, colour_r, colour_g, colour_b, colour_a,
		output extent_out, speed_x_out, speed_y_out,
		input ready
	);
	modport sink (
		input valid, new_age, expired, colour_r, colour_g, colour_b, colour_a,
		input extent_out, speed_x_out, speed_y_out,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/particle_age_interpolate_update.sv @@
`default_nettype none

// Particle update pipeline.
// particle: one particle record per word (age, lifetime, start/end colour and
//   size, gravity, velocity). result: one updated record per word.
// The frame step is written over the APB port at address 0 and read back
//   there; write it only while no word is in flight.
// An accepted particle word passes one input stage, eight divider stages that
//   each resolve two bits of the normalized age t, one multiply stage and one
//   output register on its way to its result word. The divider is the deepest
//   unit; throughput is one word per cycle while result.ready is high.
// Each stage has its own valid bit and moves whenever the stage after it is
//   empty or moving, so when the receiver stalls the pipeline fills up behind
//   the output register and particle.ready drops only once every stage holds
//   a word. Nothing is lost or repeated across a stall.
// Reset clears all valid bits and the frame step to zero.
// Expired particles return their velocity unchanged with colour and size zero.
module particle_age_interpolate_update (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pai_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	pai_in_if.sink particle,
	pai_out_if.source result
);
	import pai_pkg::*;

	// gravity step rounding and saturating add
	function automatic logic [31:0] sat_speed(input logic [31:0] s, input logic neg,
			input logic [63:0] prod);
		logic [63:0] rnd;
		logic [47:0] step;
		logic signed [49:0] sum;
		rnd = prod + HALF_Q16;
		step = rnd[63:16];
		if (neg) begin
			sum = $signed({{18{s[31]}}, s}) - $signed({2'b00, step});
		end else begin
			sum = $signed({{18{s[31]}}, s}) + $signed({2'b00, step});
		end
		if (sum > 50'sd2147483647) begin
			sat_speed = 32'h7fff_ffff;
		end else if (sum < -50'sd2147483648) begin
			sat_speed = 32'h8000_0000;
		end else begin
			sat_speed = sum[31:0];
		end
	endfunction

	logic [31:0] time_step_q;

	rec_t rec_s1;
	logic vld_s1;
	rec_t div_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] div_vld_s;
	mul_t mul_s10;
	logic vld_s10;
	res_t out_s11;
	logic vld_s11;

	logic en_s1;
	logic [DIV_STAGES-1:0] en_div;
	logic en_s10;
	logic en_s11;

	// register port
	assign pready = 1'b1;
	always_comb begin
		if (paddr[ADDR_W-1 -: 1] == REG_TIME_STEP) begin
			prdata = time_step_q;
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= '0;
		end else if (psel && penable && pwrite && pready &&
				paddr[ADDR_W-1 -: 1] == REG_TIME_STEP) begin
			time_step_q <= pwdata;
		end
	end

	// stage enables, from the output back
	always_comb begin
		en_s11 = !vld_s11 || result.ready;
		en_s10 = !vld_s10 || en_s11;
		en_div[DIV_STAGES-1] = !div_vld_s[DIV_STAGES-1] || en_s10;
		for (int k = DIV_STAGES - 2; k >= 0; k--) begin
			en_div[k] = !div_vld_s[k] || en_div[k+1];
		end
		en_s1 = !vld_s1 || en_div[0];
	end

	assign particle.ready = en_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			div_vld_s <= '0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			if (en_s1) begin
				vld_s1 <= particle.valid;
			end
			if (en_div[0]) begin
				div_vld_s[0] <= vld_s1;
			end
			for (int k = 1; k < DIV_STAGES; k++) begin
				if (en_div[k]) begin
					div_vld_s[k] <= div_vld_s[k-1];
				end
			end
			if (en_s10) begin
				vld_s10 <= div_vld_s[DIV_STAGES-1];
			end
			if (en_s11) begin
				vld_s11 <= vld_s10;
			end
		end
	end

	// stage 1: age update, expiry test, gravity magnitudes
	rec_t rec_d1;
	always_comb begin
		logic [32:0] sum;
		sum = {1'b0, particle.particle_age} + {1'b0, time_step_q};
		rec_d1 = '0;
		rec_d1.na = sum[32] ? 32'hffff_ffff : sum[31:0];
		rec_d1.expired = (rec_d1.na >= particle.life_span);
		rec_d1.life = particle.life_span;
		rec_d1.rem = rec_d1.na;
		rec_d1.sc = particle.start_colour;
		rec_d1.ec = particle.end_colour;
		rec_d1.se = particle.start_extent;
		rec_d1.ee = particle.end_extent;
		rec_d1.neg_x = particle.pull_x[31];
		rec_d1.neg_y = particle.pull_y[31];
		rec_d1.mag_x = particle.pull_x[31] ? (~particle.pull_x + 32'd1) : particle.pull_x;
		rec_d1.mag_y = particle.pull_y[31] ? (~particle.pull_y + 32'd1) : particle.pull_y;
		rec_d1.spx = particle.speed_x_in;
		rec_d1.spy = particle.speed_y_in;
	end

	always_ff @(posedge clk) begin
		if (en_s1 && particle.valid) begin
			rec_s1 <= rec_d1;
		end
	end

	// divider stages: restoring division of age*2^16 by lifetime
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		rec_t prev;
		rec_t nxt;
		logic prev_vld;

		if (k == 0) begin : g_first
			assign prev = rec_s1;
			assign prev_vld = vld_s1;
		end else begin : g_rest
			assign prev = div_s[k-1];
			assign prev_vld = div_vld_s[k-1];
		end

		always_comb begin
			logic [32:0] sh;
			nxt = prev;
			for (int j = 0; j < DIV_BITS; j++) begin
				sh = {nxt.rem, 1'b0};
				if (sh >= {1'b0, nxt.life}) begin
					sh = sh - {1'b0, nxt.life};
					nxt.rem = sh[31:0];
					nxt.quo = {nxt.quo[Q_W-2:0], 1'b1};
				end else begin
					nxt.rem = sh[31:0];
					nxt.quo = {nxt.quo[Q_W-2:0], 1'b0};
				end
			end
			// gravity multiply rides along the first stage, rounding in the second
			if (k == 0) begin
				nxt.prod_x = {32'd0, prev.mag_x} * {32'd0, time_step_q};
				nxt.prod_y = {32'd0, prev.mag_y} * {32'd0, time_step_q};
			end
			if (k == 1) begin
				nxt.vx = sat_speed(prev.spx, prev.neg_x, prev.prod_x);
				nxt.vy = sat_speed(prev.spy, prev.neg_y, prev.prod_y);
			end
		end

		always_ff @(posedge clk) begin
			if (en_div[k] && prev_vld) begin
				div_s[k] <= nxt;
			end
		end
	end

	// stage 10: t times (end - start) per channel and for the size
	mul_t mul_d10;
	always_comb begin
		logic signed [25:0] cd;
		logic signed [49:0] ed;
		logic signed [25:0] tc;
		logic signed [49:0] te;
		rec_t last;
		last = div_s[DIV_STAGES-1];
		tc = $signed({10'd0, last.quo});
		te = $signed({34'd0, last.quo});
		mul_d10.na = last.na;
		mul_d10.expired = last.expired;
		mul_d10.sc = last.sc;
		mul_d10.se = last.se;
		mul_d10.spx = last.spx;
		mul_d10.spy = last.spy;
		mul_d10.vx = last.vx;
		mul_d10.vy = last.vy;
		for (int ch = 0; ch < 4; ch++) begin
			cd = $signed({18'd0, last.ec[8*ch +: 8]}) - $signed({18'd0, last.sc[8*ch +: 8]});
			mul_d10.cprod[ch] = tc * cd;
		end
		ed = $signed({18'd0, last.ee}) - $signed({18'd0, last.se});
		mul_d10.eprod = te * ed;
	end

	always_ff @(posedge clk) begin
		if (en_s10 && div_vld_s[DIV_STAGES-1]) begin
			mul_s10 <= mul_d10;
		end
	end

	// stage 11: add start value, round, select expired outputs
	res_t out_d11;
	always_comb begin
		logic signed [26:0] cv;
		logic signed [50:0] ev;
		logic [25:0] cp;
		out_d11.na = mul_s10.na;
		out_d11.expired = mul_s10.expired;
		for (int ch = 0; ch < 4; ch++) begin
			cp = mul_s10.cprod[ch];
			cv = $signed({3'b000, mul_s10.sc[8*ch +: 8], 16'h0000}) +
				$signed({cp[25], cp}) + 27'sd32768;
			out_d11.colour[ch] = mul_s10.expired ? 8'd0 : cv[23:16];
		end
		ev = $signed({3'b000, mul_s10.se, 16'h0000}) +
			$signed({mul_s10.eprod[49], mul_s10.eprod}) + 51'sd32768;
		out_d11.extent = mul_s10.expired ? 32'd0 : ev[47:16];
		out_d11.sx = mul_s10.expired ? mul_s10.spx : mul_s10.vx;
		out_d11.sy = mul_s10.expired ? mul_s10.spy : mul_s10.vy;
	end

	always_ff @(posedge clk) begin
		if (en_s11 && vld_s10) begin
			out_s11 <= out_d11;
		end
	end

	// result word
	assign result.valid = vld_s11;
	assign result.new_age = out_s11.na;
	assign result.expired = out_s11.expired;
	assign result.colour_r = out_s11.colour[0];
	assign result.colour_g = out_s11.colour[1];
	assign result.colour_b = out_s11.colour[2];
	assign result.colour_a = out_s11.colour[3];
	assign result.extent_out = out_s11.extent;
	assign result.speed_x_out = out_s11.sx;
	assign result.speed_y_out = out_s11.sy;

	// an accepted word always lands in the input stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		particle.valid && particle.ready |=> vld_s1)
		else $error("accepted particle word not captured");

	// a live particle leaves the divider with a remainder below its lifetime
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_s[DIV_STAGES-1] && !div_s[DIV_STAGES-1].expired |->
		div_s[DIV_STAGES-1].rem < div_s[DIV_STAGES-1].life)
		else $error("divider remainder out of range");

	// a full pipeline behind a stalled output takes no word
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready && vld_s10 && vld_s1 && (&div_vld_s) |->
		!particle.ready)
		else $error("word accepted into a full stalled pipeline");

endmodule

`default_nettype wire

@@ tb/particle_update_checker.sv @@
`timescale 1ns / 100ps

module particle_update_checker (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [pai_pkg::ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic pready,
	pai_in_if particle,
	pai_out_if result,
	output int fails,
	output int results_seen
);
	import pai_pkg::*;

	localparam logic [ADDR_W-1:0] STEP_ADDR = ADDR_W'(4 * REG_TIME_STEP);
	localparam logic [16:0] T_ONE = 17'h10000;
	localparam longint SPEED_MAX = 64'sd2147483647;
	localparam longint SPEED_MIN = -64'sd2147483648;

	logic [31:0] frame_step;
	res_t updated_q[$];
	res_t want;

	// linear blend from a to b, t in Q1.16, round half up
	function automatic logic [31:0] lerp_q16(input logic [31:0] a, input logic [31:0] b,
		input logic [16:0] t);
		logic [63:0] acc;
		if (t == 17'd0)
			return a;
		if (t >= T_ONE)
			return b;
		acc = 64'(a) << 16;
		if (b >= a)
			acc = acc + 64'(t) * 64'(b - a);
		else
			acc = acc - 64'(t) * 64'(a - b);
		return 32'((acc + 64'd32768) >> 16);
	endfunction

	// velocity plus rounded gravity step, clamped to the signed 32 bit range
	function automatic logic [31:0] add_gravity(input logic [31:0] speed,
		input logic [31:0] pull, input logic [31:0] dt);
		logic [31:0] neg_pull;
		logic [63:0] mag;
		logic [63:0] stp;
		longint sum;
		neg_pull = ~pull + 32'd1;
		mag = pull[31] ? 64'(neg_pull) : 64'(pull);
		stp = (mag * 64'(dt) + 64'd32768) >> 16;
		sum = longint'(signed'(speed));
		sum = pull[31] ? sum - longint'(stp) : sum + longint'(stp);
		if (sum > SPEED_MAX)
			sum = SPEED_MAX;
		if (sum < SPEED_MIN)
			sum = SPEED_MIN;
		return 32'(sum);
	endfunction

	// updated particle record for one accepted word
	function automatic res_t age_particle(input logic [31:0] age, input logic [31:0] life,
		input logic [31:0] sc, input logic [31:0] ec, input logic [31:0] se,
		input logic [31:0] ee, input logic [31:0] px, input logic [31:0] py,
		input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] dt);
		res_t r;
		logic [32:0] wide;
		logic [31:0] na;
		logic [63:0] ratio;
		logic [16:0] t;
		wide = {1'b0, age} + {1'b0, dt};
		na = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
		r = '0;
		r.na = na;
		if (na >= life) begin
			r.expired = 1'b1;
			r.sx = vx;
			r.sy = vy;
			return r;
		end
		ratio = (64'(na) << 16) / 64'(life);
		t = (ratio > 64'(T_ONE)) ? T_ONE : ratio[16:0];
		for (int ch = 0; ch < 4; ch++)
			r.colour[ch] = 8'(lerp_q16(32'(sc[8*ch +: 8]), 32'(ec[8*ch +: 8]), t));
		r.extent = lerp_q16(se, ee, t);
		r.sx = add_gravity(vx, px, dt);
		r.sy = add_gravity(vy, py, dt);
		return r;
	endfunction

	task automatic compare(input string what, input logic [31:0] exp, input logic [31:0] act);
		if (exp !== act) begin
			$display("%0t %s mismatch: expected %h actual %h", $time, what, exp, act);
			fails++;
		end
	endtask

	// track the frame step, predict on accept, check on each result word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_step = '0;
			updated_q.delete();
			fails = 0;
			results_seen = 0;
		end else begin
			if (psel && penable && pready && paddr == STEP_ADDR) begin
				if (pwrite)
					frame_step = pwdata;
				else
					compare("time_step readback", frame_step, prdata);
			end
			if (particle.valid && particle.ready)
				updated_q.push_back(age_particle(particle.particle_age, particle.life_span,
					particle.start_colour, particle.end_colour, particle.start_extent,
					particle.end_extent, particle.pull_x, particle.pull_y,
					particle.speed_x_in, particle.speed_y_in, frame_step));
			if (result.valid && result.ready) begin
				if (updated_q.size() == 0) begin
					$display("%0t unexpected result word: expected none actual age %h",
						$time, result.new_age);
					fails++;
				end else begin
					want = updated_q.pop_front();
					compare("new_age", want.na, result.new_age);
					compare("expired", 32'(want.expired), 32'(result.expired));
					compare("colour_r", 32'(want.colour[0]), 32'(result.colour_r));
					compare("colour_g", 32'(want.colour[1]), 32'(result.colour_g));
					compare("colour_b", 32'(want.colour[2]), 32'(result.colour_b));
					compare("colour_a", 32'(want.colour[3]), 32'(result.colour_a));
					compare("extent_out", want.extent, result.extent_out);
					compare("speed_x_out", want.sx, result.speed_x_out);
					compare("speed_y_out", want.sy, result.speed_y_out);
				end
				results_seen++;
			end
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import pai_pkg::*;

	localparam logic [ADDR_W-1:0] STEP_ADDR = ADDR_W'(4 * REG_TIME_STEP);
	localparam int PIPE_DEPTH = 11;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [31:0] age;
		logic [31:0] life;
		logic [31:0] sc;
		logic [31:0] ec;
		logic [31:0] se;
		logic [31:0] ee;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] vx;
		logic [31:0] vy;
	} particle_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int fails;
	int results_seen;
	int sent;
	int cycles;
	logic calm;

	pai_in_if particle();
	pai_out_if result();

	particle_age_interpolate_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.particle(particle),
		.result(result)
	);

	particle_update_checker update_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.particle(particle),
		.result(result),
		.fails(fails),
		.results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run time guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver backpressure
	always @(posedge clk)
		result.ready <= calm || ($urandom_range(0, 99) >= 9);

	function automatic particle_t make_particle(input logic [31:0] age, input logic [31:0] life,
		input logic [31:0] sc, input logic [31:0] ec, input logic [31:0] se,
		input logic [31:0] ee, input logic [31:0] px, input logic [31:0] py,
		input logic [31:0] vx, input logic [31:0] vy);
		particle_t p;
		p = '{age, life, sc, ec, se, ee, px, py, vx, vy};
		return p;
	endfunction

	// mostly live particles, some right at the lifetime edge, some pure noise
	function automatic particle_t random_particle(input logic [31:0] step);
		particle_t p;
		int kind;
		logic [32:0] wide;
		logic [31:0] na;
		kind = $urandom_range(0, 99);
		p.sc = $urandom;
		p.ec = $urandom;
		p.se = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h3_0000) : $urandom;
		p.ee = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h3_0000) : $urandom;
		p.px = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h4_0000) - 32'h2_0000;
		p.py = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h4_0000) - 32'h2_0000;
		p.vx = $urandom;
		p.vy = $urandom;
		p.age = $urandom;
		p.life = $urandom;
		if (kind < 75) begin
			if ($urandom_range(0, 9) < 3)
				p.life = $urandom_range(1, 32'h8_0000);
			if (p.life == '0)
				p.life = 32'd1;
			if (step < p.life)
				p.age = $urandom_range(0, p.life - step - 1);
		end else if (kind < 87) begin
			wide = {1'b0, p.age} + {1'b0, step};
			na = wide[32] ? 32'hFFFF_FFFF : wide[31:0];
			p.life = ($urandom_range(0, 1) && na != 32'hFFFF_FFFF) ? na + 32'd1 : na;
		end
		return p;
	endfunction

	// present one word, with an occasional idle cycle before it
	task automatic send_particle(input particle_t p);
		if (!calm && $urandom_range(0, 99) < 9) begin
			particle.valid <= 1'b0;
			@(posedge clk);
		end
		particle.valid <= 1'b1;
		particle.particle_age <= p.age;
		particle.life_span <= p.life;
		particle.start_colour <= p.sc;
		particle.end_colour <= p.ec;
		particle.start_extent <= p.se;
		particle.end_extent <= p.ee;
		particle.pull_x <= p.px;
		particle.pull_y <= p.py;
		particle.speed_x_in <= p.vx;
		particle.speed_y_in <= p.vy;
		do @(posedge clk); while (!particle.ready);
		sent++;
	endtask

	// drain the pipeline before touching the register
	task automatic settle();
		particle.valid <= 1'b0;
		while (results_seen != sent) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= STEP_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_step(input logic [31:0] step);
		settle();
		apb_access(1'b1, step);
		apb_access(1'b0, '0);
	endtask

	task automatic run_random(input logic [31:0] step, input int count);
		set_step(step);
		for (int i = 0; i < count; i++)
			send_particle(random_particle(step));
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		sent = 0;
		cycles = 0;
		result.ready = 1'b0;
		particle.valid = 1'b0;
		particle.particle_age = '0;
		particle.life_span = '0;
		particle.start_colour = '0;
		particle.end_colour = '0;
		particle.start_extent = '0;
		particle.end_extent = '0;
		particle.pull_x = '0;
		particle.pull_y = '0;
		particle.speed_x_in = '0;
		particle.speed_y_in = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// frame step still at its reset value of zero
		apb_access(1'b0, '0);
		// zero lifetime expires at once, velocity passes through
		send_particle(make_particle(0, 0, '1, '1, '1, '1, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000));
		// t of zero gives the start values exactly
		send_particle(make_particle(0, 1, 32'hFF00_FF00, 32'h00FF_00FF, '1, 0,
			32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 32'h8765_4321));
		// half way between 0 and 1 rounds up
		send_particle(make_particle(5, 10, 0, 32'h0101_0101, 0, 1, 1, '1, 0, 0));
		// t just under one
		send_particle(make_particle(32'hFFFF_FFFE, '1, 32'h0000_00FF, 0, 0, '1, 0, 0, 0, 0));
		// age equal to lifetime expires
		send_particle(make_particle('1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
		send_particle(make_particle(7, 7, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 9, 3, 0, 0, 5, 6));

		// half a second per frame
		set_step(32'h0000_8000);
		// gravity step of exactly one half rounds away from zero
		send_particle(make_particle(0, 32'h0001_0000, 32'h8040_2010, 32'h0102_0408,
			32'h0001_0000, 32'h0003_0000, 1, '1, 0, 0));
		// velocity saturates both ways
		send_particle(make_particle(0, '1, 0, '1, 0, '1, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000));
		// new age saturates, then lands just below the ceiling
		send_particle(make_particle(32'hFFFF_FFF0, '1, '1, 0, '1, 0, 3, 4, 1, 2));
		send_particle(make_particle(32'hFFFF_7FFE, '1, '1, 0, '1, 0, 3, 4, 1, 2));
		// falling colour and size
		send_particle(make_particle(32'h4000, 32'h2_0000, '1, 0, '1, 32'h10, 32'hFFFE_0000,
			32'h0002_0000, 32'h8000_0005, 32'h7FFF_FFF0));

		// largest frame step: every particle expires
		set_step('1);
		send_particle(make_particle(0, '1, '1, '1, '1, '1, 1, 1, 32'h0BAD_CAFE, 32'hF00D_0001));
		send_particle(make_particle(1, 32'h10, 0, 0, 0, 0, 1, 1, 3, 4));

		// large step with a live particle
		set_step(32'h7FFF_FFFF);
		send_particle(make_particle(0, '1, 32'h00FF_00FF, 32'hFF00_FF00, 0, '1,
			32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
		send_particle(make_particle(0, '1, 32'h1020_3040, 32'h4030_2010, 5, 32'h10_0000,
			32'h0000_0003, 32'hFFFF_FFFD, 32'h8000_0000, 32'h7FFF_FFFF));
		send_particle(make_particle(32'h8000_0000, '1, 0, 0, 0, 0, 1, 1, 7, 8));

		// random phases across several frame steps
		run_random(32'd1, 78);
		calm = 1'b1;
		run_random(32'h0001_0000, 78);
		calm = 1'b0;
		run_random($urandom_range(0, 32'h4_0000), 78);
		run_random(32'd0, 78);
		run_random('1, 78);
		run_random($urandom, 78);
		run_random(32'h7FFF_FFFF, 78);

		settle();
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
